// ===== rtl/moving_average_filter_top_assert.svh =====
// assertion macros for the moving average filter checker
`ifndef MOVING_AVERAGE_FILTER_TOP_ASSERT_SVH
`define MOVING_AVERAGE_FILTER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MAF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mavg_pkg.sv =====
// shared defaults and width helpers for the moving average filter
package mavg_pkg;

  // default sizing
  localparam int MAX_WINDOW_DEF     = 64;
  localparam int DEFAULT_WINDOW_DEF = 8;
  localparam int SAMPLE_BITS_DEF    = 16;

  // window register value after reset
  localparam logic [7:0] RESET_WINDOW_LENGTH = 8'd8;

  // bits for a count that can hold the value n itself
  function automatic int count_bits(input int n);
    return $clog2(n + 1);
  endfunction

endpackage

// ===== rtl/mavg_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module mavg_div #(
  parameter int DVD_BITS = 23,
  parameter int DVS_BITS = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DVD_BITS-1:0] dividend,
  input  logic [DVS_BITS-1:0] divisor,
  output logic                done,
  output logic [DVD_BITS-1:0] quotient
);

  localparam int CNT_BITS = mavg_pkg::count_bits(DVD_BITS);

  logic [DVD_BITS-1:0] quo_r;
  logic [DVS_BITS-1:0] rem_r;
  logic [DVS_BITS-1:0] dvs_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                done_r;

  logic [DVS_BITS:0]   rem_sh;
  logic [DVS_BITS:0]   diff;
  logic                take;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem_r, quo_r[DVD_BITS-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    take   = (rem_sh >= {1'b0, dvs_r});
  end

  // control: count down the quotient bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_BITS'(DVD_BITS);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        done_r <= 1'b1;
      end
    end
  end

  // datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[DVD_BITS-2:0], take};
      rem_r <= take ? diff[DVS_BITS-1:0] : rem_sh[DVS_BITS-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/moving_average_filter_top.sv =====
// moving average filter: sample store, running sum and output stage
//
// Each accepted word adds one signed sample to a circular store of the last
// W samples (W from window_length: 0 means DEFAULT_WINDOW, larger than
// MAX_WINDOW means MAX_WINDOW) and returns the running sum divided by the
// fill count, truncated toward zero, with a full flag and the fill count.
// One word is worked on at a time. The store is read at the accept edge, the
// update state then updates the sum and writes the store, and the iterative
// divider then yields one quotient bit per cycle for SAMPLE_BITS +
// clog2(MAX_WINDOW+1) bits (23 at the defaults). The output register is loaded
// once the divider is done and no result waits or the waiting one is taken,
// and the next word can be taken once it is loaded. The output register lets
// the next word enter while a result waits; that word then holds at the end
// of the divider until the waiting result is taken. Writing window_length or
// setting restart empties the filter; no clearing pass runs after reset.
module moving_average_filter_top #(
  parameter int MAX_WINDOW     = mavg_pkg::MAX_WINDOW_DEF,
  parameter int DEFAULT_WINDOW = mavg_pkg::DEFAULT_WINDOW_DEF,
  parameter int SAMPLE_BITS    = mavg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
  input  logic                          in_restart,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_average,
  output logic                          out_window_full,
  output logic [7:0]                    out_fill_count,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [7:0]                    cfg_window_length
);

  localparam int CW   = mavg_pkg::count_bits(MAX_WINDOW);
  localparam int PW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUMW = SAMPLE_BITS + CW;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_UPDATE = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;

  // clamp of the requested window
  function automatic logic [CW-1:0] clamp_window(input logic [7:0] raw);
    logic [8:0] w;
    begin
      w = (raw == 8'd0) ? 9'(DEFAULT_WINDOW) : {1'b0, raw};
      if (w > 9'(MAX_WINDOW)) begin
        w = 9'(MAX_WINDOW);
      end
      return w[CW-1:0];
    end
  endfunction

  logic [1:0]                   state_r, state_nxt;
  logic [CW-1:0]                window_r;
  logic signed [SUMW-1:0]       sum_r;
  logic [CW-1:0]                held_r;
  logic [PW-1:0]                wpos_r;
  logic [PW-1:0]                pos_r;
  logic [SAMPLE_BITS-1:0]       sample_r;
  logic [SAMPLE_BITS-1:0]       rd_data_r;
  logic                         neg_r;

  logic                         out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_average_r;
  logic                         out_window_full_r;
  logic [7:0]                   out_fill_count_r;

  logic [SAMPLE_BITS-1:0]       store_mem [MAX_WINDOW];

  logic                         in_acc;
  logic                         cfg_acc;
  logic                         out_free;
  logic [PW-1:0]                rd_pos;
  logic                         was_full;
  logic signed [SUMW-1:0]       sum_nxt;
  logic [CW-1:0]                held_nxt;
  logic [CW-1:0]                pos_inc;
  logic [PW-1:0]                wpos_nxt;
  logic [SUMW-1:0]              sum_mag;
  logic                         div_start;
  logic                         div_done;
  logic [SUMW-1:0]              div_quo;
  logic [SUMW-1:0]              avg_full;

  // handshakes
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || out_ready;

  // store position for the incoming word
  always_comb begin
    if (in_restart || (CW'(wpos_r) >= window_r)) begin
      rd_pos = '0;
    end else begin
      rd_pos = wpos_r;
    end
  end

  // running sum update with the oldest sample leaving once full
  always_comb begin
    was_full = (held_r >= window_r);
    sum_nxt  = sum_r + SUMW'($signed(sample_r));
    if (was_full) begin
      sum_nxt = sum_nxt - SUMW'($signed(rd_data_r));
    end
    held_nxt = was_full ? held_r : held_r + 1'b1;
    pos_inc  = CW'(pos_r) + 1'b1;
    wpos_nxt = (pos_inc >= window_r) ? '0 : pos_inc[PW-1:0];
    sum_mag  = sum_nxt[SUMW-1] ? SUMW'(-sum_nxt) : SUMW'(sum_nxt);
  end

  assign div_start = (state_r == ST_UPDATE);

  // state sequencing
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // filter control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      window_r <= clamp_window(mavg_pkg::RESET_WINDOW_LENGTH);
      sum_r    <= '0;
      held_r   <= '0;
      wpos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        window_r <= clamp_window(cfg_window_length);
        sum_r    <= '0;
        held_r   <= '0;
        wpos_r   <= '0;
      end else if (in_acc && in_restart) begin
        sum_r  <= '0;
        held_r <= '0;
      end else if (state_r == ST_UPDATE) begin
        sum_r  <= sum_nxt;
        held_r <= held_nxt;
        wpos_r <= wpos_nxt;
      end
    end
  end

  // word capture and sign of the quotient
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos_r    <= rd_pos;
      sample_r <= in_sample_value;
    end
    if (state_r == ST_UPDATE) begin
      neg_r <= sum_nxt[SUMW-1];
    end
  end

  // sample store read port
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= store_mem[rd_pos];
    end
  end

  // sample store write port
  always_ff @(posedge clk) begin
    if (state_r == ST_UPDATE) begin
      store_mem[pos_r] <= sample_r;
    end
  end

  // divider for sum over fill count
  mavg_div #(
    .DVD_BITS (SUMW),
    .DVS_BITS (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (held_nxt),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign avg_full = neg_r ? (~div_quo + 1'b1) : div_quo;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DIV && div_done && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV && div_done && out_free) begin
      out_average_r     <= avg_full[SAMPLE_BITS-1:0];
      out_window_full_r <= (held_r >= window_r);
      out_fill_count_r  <= 8'(held_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_average     = out_average_r;
  assign out_window_full = out_window_full_r;
  assign out_fill_count  = out_fill_count_r;

endmodule

// ===== rtl/mavg_chk.sv =====
// port checker for the moving average filter, bound to the top level
`include "moving_average_filter_top_assert.svh"

module mavg_chk #(
  parameter int MAX_WINDOW  = mavg_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_average,
  input logic                          out_window_full,
  input logic [7:0]                    out_fill_count
);

  // a stalled result holds its word
  `MAF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_average) && $stable(out_fill_count), "result changed while stalled")

  // one word at a time: no accept right after an accept
  `MAF_ASSERT_NEXT(a_in_one_at_a_time, in_valid && in_ready, !in_ready,
    "input accepted while a word is in work")

  // fill count lies in the window range
  `MAF_ASSERT_NOW(a_fill_range, out_valid,
    (out_fill_count != 8'd0) && (out_fill_count <= 8'(MAX_WINDOW)), "fill count out of range")

  // a result with the largest window count is full
  `MAF_ASSERT_NOW(a_full_at_max, out_valid && (out_fill_count == 8'(MAX_WINDOW)),
    out_window_full, "full flag missing at maximum window")

endmodule

bind moving_average_filter_top mavg_chk #(
  .MAX_WINDOW  (MAX_WINDOW),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mavg_chk (.*);
